### sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, side-band payload type and arctangent table for the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int COMP_W   = 16;   // Q1.14 component
    localparam int PROD_W   = 32;   // full product of two components
    localparam int OP_W     = 36;   // Q.28 atan2 operand
    localparam int T_W      = 30;   // saturated asin argument
    localparam int SQ_W     = 58;   // square root radicand and remainder
    localparam int ROOT_W   = 29;   // square root result
    localparam int ISQ_STG  = 29;   // one result bit per stage
    localparam int CW       = 54;   // cordic vector width
    localparam int AW       = 34;   // cordic angle accumulator, Q.30
    localparam int ANG_W    = 16;   // Q2.13 angle
    localparam int PITCH_W  = 15;
    localparam int ATAN_LEN = 24;

    localparam logic signed [OP_W-1:0] ONE_Q28   = 36'sd268435456;
    localparam logic [SQ_W-1:0]        ONE_Q56   = 58'd1 << 56;
    localparam logic signed [AW-1:0]   HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;

    // operands carried alongside the square root
    typedef struct packed {
        logic signed [T_W-1:0]  t;
        logic signed [OP_W-1:0] yaw_y;
        logic signed [OP_W-1:0] yaw_x;
        logic signed [OP_W-1:0] roll_y;
        logic signed [OP_W-1:0] roll_x;
        logic                   clip;
    } side_t;

    // atan(2^-i) in Q.30, rounded
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Pairwise products, the three angle arguments, asin saturation and the
// square root radicand, in four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front
    import qte_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [COMP_W-1:0] x,
    input  wire logic signed [COMP_W-1:0] y,
    input  wire logic signed [COMP_W-1:0] z,
    input  wire logic signed [COMP_W-1:0] w,
    output logic                          out_valid,
    output logic [SQ_W-1:0]               out_rad,
    output side_t                         out_side
);

    logic signed [PROD_W-1:0] xx_reg, xy_reg, xz_reg, xw_reg, yy_reg;
    logic signed [PROD_W-1:0] yz_reg, yw_reg, zz_reg, zw_reg, ww_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    side_t                    s2_reg, s3_reg, s4_reg;
    side_t                    s2_next;
    logic [SQ_W-1:0]          tt_reg, rad_reg;
    logic signed [2*T_W-1:0]  tt_full;
    logic signed [OP_W-1:0]   t_raw;

    function automatic logic signed [OP_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        return {{(OP_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    always_comb begin
        t_raw = (ext(xz_reg) - ext(yw_reg)) <<< 1;
        s2_next.clip = 1'b0;
        if (t_raw > ONE_Q28) begin
            s2_next.t    = ONE_Q28[T_W-1:0];
            s2_next.clip = 1'b1;
        end else if (t_raw < -ONE_Q28) begin
            s2_next.t    = -ONE_Q28[T_W-1:0];
            s2_next.clip = 1'b1;
        end else begin
            s2_next.t    = t_raw[T_W-1:0];
        end
        s2_next.yaw_y  = (ext(yz_reg) + ext(xw_reg)) <<< 1;
        s2_next.yaw_x  = ext(xx_reg) + ext(yy_reg) - ext(zz_reg) - ext(ww_reg);
        s2_next.roll_y = (ext(zw_reg) + ext(xy_reg)) <<< 1;
        s2_next.roll_x = ext(xx_reg) - ext(yy_reg) - ext(zz_reg) + ext(ww_reg);
    end

    assign tt_full = s2_reg.t * s2_reg.t;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg  <= x * x;
            xy_reg  <= x * y;
            xz_reg  <= x * z;
            xw_reg  <= x * w;
            yy_reg  <= y * y;
            yz_reg  <= y * z;
            yw_reg  <= y * w;
            zz_reg  <= z * z;
            zw_reg  <= z * w;
            ww_reg  <= w * w;
            s2_reg  <= s2_next;
            // t*t never exceeds 2^56, so the low bits hold it unsigned
            tt_reg  <= tt_full[SQ_W-1:0];
            s3_reg  <= s2_reg;
            rad_reg <= ONE_Q56 - tt_reg;
            s4_reg  <= s3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_rad   = rad_reg;
    assign out_side  = s4_reg;

endmodule

`default_nettype wire

### sv/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Floor integer square root, one result bit per register stage, with the
// side-band operands carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt
    import qte_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SQ_W-1:0]   in_rad,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output side_t                  out_side
);

    logic [SQ_W-1:0] rem_reg  [0:ISQ_STG];
    logic [SQ_W-1:0] root_reg [0:ISQ_STG];
    side_t           side_reg [0:ISQ_STG];
    logic            v_reg    [0:ISQ_STG];

    always_comb begin
        rem_reg[0]  = in_rad;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        v_reg[0]    = in_valid;
    end

    for (genvar j = 0; j < ISQ_STG; j++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = 58'd1 << (2 * (ISQ_STG - 1 - j));
        logic [SQ_W-1:0] trial;
        assign trial = root_reg[j] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j+1] <= side_reg[j];
                if (rem_reg[j] >= trial) begin
                    rem_reg[j+1]  <= rem_reg[j] - trial;
                    root_reg[j+1] <= (root_reg[j] >> 1) + BIT;
                end else begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j] >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[ISQ_STG];
    assign out_root  = root_reg[ISQ_STG][ROOT_W-1:0];
    assign out_side  = side_reg[ISQ_STG];

endmodule

`default_nettype wire

### sv/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring cordic atan2: a quadrant turn stage, STAGES micro-rotation
// stages and a rounding and clamping stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = 14
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic signed [OP_W-1:0] in_y,
    input  wire logic signed [OP_W-1:0] in_x,
    output logic                        out_valid,
    output logic signed [ANG_W-1:0]     out_angle
);

    logic signed [CW-1:0] cx_reg  [0:STAGES];
    logic signed [CW-1:0] cy_reg  [0:STAGES];
    logic signed [AW-1:0] ang_reg [0:STAGES];
    logic                 zero_reg[0:STAGES];
    logic                 v_reg   [0:STAGES];
    logic                 vo_reg;
    logic signed [ANG_W-1:0] angle_reg;

    logic signed [CW-1:0]    xs, ys;
    logic signed [AW-1:0]    rnd;
    logic signed [AW-18:0]   q;
    logic signed [ANG_W-1:0] angle_next;

    assign xs = {{(CW-OP_W-16){in_x[OP_W-1]}}, in_x, 16'd0};
    assign ys = {{(CW-OP_W-16){in_y[OP_W-1]}}, in_y, 16'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (xs < 0) begin
                if (ys >= 0) begin
                    cx_reg[0]  <= ys;
                    cy_reg[0]  <= -xs;
                    ang_reg[0] <= HALF_PI_Q30;
                end else begin
                    cx_reg[0]  <= -ys;
                    cy_reg[0]  <= xs;
                    ang_reg[0] <= -HALF_PI_Q30;
                end
            end else begin
                cx_reg[0]  <= xs;
                cy_reg[0]  <= ys;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic [4:0] IDX = 5'(i);
        logic signed [AW-1:0] da;
        assign da = {{(AW-32){1'b0}}, atan_q30(IDX)};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (cy_reg[i] >= 0) begin
                    cx_reg[i+1]  <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1]  <= cy_reg[i] - (cx_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] + da;
                end else begin
                    cx_reg[i+1]  <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1]  <= cy_reg[i] + (cx_reg[i] >>> i);
                    ang_reg[i+1] <= ang_reg[i] - da;
                end
            end
        end
    end

    // round Q.30 to Q.13, half up, then clamp to +-pi; a zero vector gives zero
    always_comb begin
        rnd = ang_reg[STAGES] + 34'sd65536;
        q   = rnd[AW-1:17];
        if (zero_reg[STAGES]) begin
            angle_next = '0;
        end else if (q > 17'(PI_Q13)) begin
            angle_next = PI_Q13;
        end else if (q < -17'(PI_Q13)) begin
            angle_next = -PI_Q13;
        end else begin
            angle_next = q[ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_angle = angle_reg;

endmodule

`default_nettype wire

### sv/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Quaternion (Q1.14) to Z-Y-X Euler angles (Q2.13 radians, pitch Q1.13), fully pipelined.
// ----------------------------------------------------------------------------
// One item per cycle enters and one result per cycle leaves while the output
// is not stalled. Products and arguments come first, then a 29-stage
// bit-per-stage square root for the asin cosine term, and then three
// parallel cordic pipelines. The whole pipeline holds while a result waits
// at the output register, so s_tready follows the output handshake.
`default_nettype none

module quaternion_to_euler
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // comp_x, comp_y, comp_z, comp_w
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // pitch_angle, yaw_angle, roll_angle, arg_clipped
);

    localparam int CDLY = CORDIC_STAGES + 2;

    logic            en;
    logic            f_valid, q_valid;
    logic [SQ_W-1:0] f_rad;
    side_t           f_side, q_side;
    logic [ROOT_W-1:0] q_root;
    logic            p_valid, y_valid, r_valid;
    logic signed [ANG_W-1:0] p_ang, y_ang, r_ang;
    logic signed [PITCH_W-1:0] pitch;
    logic            clip_reg [0:CDLY-1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x         (s_tdata[15:0]),
        .y         (s_tdata[31:16]),
        .z         (s_tdata[47:32]),
        .w         (s_tdata[63:48]),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_side  (f_side)
    );

    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_y      ({{(OP_W-T_W){q_side.t[T_W-1]}}, q_side.t}),
        .in_x      ({{(OP_W-ROOT_W){1'b0}}, q_root}),
        .out_valid (p_valid),
        .out_angle (p_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_y      (q_side.yaw_y),
        .in_x      (q_side.yaw_x),
        .out_valid (y_valid),
        .out_angle (y_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_y      (q_side.roll_y),
        .in_x      (q_side.roll_x),
        .out_valid (r_valid),
        .out_angle (r_ang)
    );

    // clip flag rides alongside the cordic stages
    always_ff @(posedge aclk) begin
        if (en) begin
            clip_reg[0] <= q_side.clip;
            for (int k = 1; k < CDLY; k++) begin
                clip_reg[k] <= clip_reg[k-1];
            end
        end
    end

    always_comb begin
        if (p_ang > HALF_PI_Q13) begin
            pitch = HALF_PI_Q13[PITCH_W-1:0];
        end else if (p_ang < -HALF_PI_Q13) begin
            pitch = -HALF_PI_Q13[PITCH_W-1:0];
        end else begin
            pitch = p_ang[PITCH_W-1:0];
        end
    end

    assign m_tvalid = p_valid;
    assign m_tdata  = {clip_reg[CDLY-1], r_ang, y_ang, pitch};

    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid == y_valid) && (p_valid == r_valid))
        else $error("cordic lanes out of step");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd12868 &&
                      $signed(m_tdata[14:0]) >= -15'sd12868))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[30:15]) <= 16'sd25736 &&
                      $signed(m_tdata[30:15]) >= -16'sd25736))
        else $error("yaw out of range");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the quaternion to Euler angle pipeline against a bit-exact predictor
// of the product, square root and cordic arithmetic, with random stalls on
// both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import qte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = 14;
    localparam int LATENCY   = 4 + 29 + STAGES + 2;
    localparam longint LIMIT = 2000000;

    // field order matches m_tdata, highest bits first
    typedef struct packed {
        logic               clip;
        logic [ANG_W-1:0]   roll;
        logic [ANG_W-1:0]   yaw;
        logic [PITCH_W-1:0] pitch;
    } angles_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    angles_t     expected_angles[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          clipped_seen = 0;
    int          stall_left = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;

    quaternion_to_euler #(.CORDIC_STAGES(STAGES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t", $time);
            $display("quaternion_to_euler verification failed");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint cx, cy, ang, nx, ny, q;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        cx = xv * 65536;
        cy = yv * 65536;
        // left half plane: rotate by a quarter turn first
        if (cx < 0) begin
            if (cy >= 0) begin
                nx = cy; ny = -cx; ang = HALF_PI_Q30;
            end else begin
                nx = -cy; ny = cx; ang = -HALF_PI_Q30;
            end
            cx = nx; cy = ny;
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            if (cy >= 0) begin
                nx = cx + floor_shift(cy, i);
                ny = cy - floor_shift(cx, i);
                ang += longint'(atan_q30(i[4:0]));
            end else begin
                nx = cx - floor_shift(cy, i);
                ny = cy + floor_shift(cx, i);
                ang -= longint'(atan_q30(i[4:0]));
            end
            cx = nx; cy = ny;
        end
        q = floor_shift(ang + 65536, 17);
        if (q > PI_Q13) q = PI_Q13;
        if (q < -PI_Q13) q = -PI_Q13;
        return q;
    endfunction

    function automatic angles_t euler_of(logic [63:0] quat);
        longint x, y, z, w, t, c, p, one;
        angles_t r;
        x = longint'($signed(quat[15:0]));
        y = longint'($signed(quat[31:16]));
        z = longint'($signed(quat[47:32]));
        w = longint'($signed(quat[63:48]));
        one = 64'sd1 << 28;
        t = 2 * (x * z - y * w);
        r.clip = 1'b0;
        if (t > one) begin t = one; r.clip = 1'b1; end
        if (t < -one) begin t = -one; r.clip = 1'b1; end
        c = int_sqrt(longint'(one * one - t * t));
        p = vector_angle(t, c);
        if (p > HALF_PI_Q13) p = HALF_PI_Q13;
        if (p < -HALF_PI_Q13) p = -HALF_PI_Q13;
        r.pitch = p[PITCH_W-1:0];
        r.yaw = ANG_W'(vector_angle(2 * (y * z + x * w),
            x * x + y * y - z * z - w * w));
        r.roll = ANG_W'(vector_angle(2 * (z * w + x * y),
            x * x - y * y - z * z + w * w));
        return r;
    endfunction

    // sender: offers one quaternion, with an optional random gap first
    task automatic send_quat(logic [15:0] x, y, z, w, bit gaps);
        int gap;
        if (gaps) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tdata = {w, z, y, x};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_angles.push_back(euler_of({w, z, y, x}));
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // receiver: random ready with a rare long stall, forced low during hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_left = $urandom_range(10, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge aclk) begin
        angles_t got, exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[47:0];
            results_seen++;
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                exp_a = expected_angles.pop_front();
                if (got.clip) clipped_seen++;
                if (got.pitch !== exp_a.pitch || got.yaw !== exp_a.yaw ||
                        got.roll !== exp_a.roll || got.clip !== exp_a.clip) begin
                    $display("%0t: expected pitch %0d yaw %0d roll %0d clip %0b",
                        $time, $signed(exp_a.pitch), $signed(exp_a.yaw),
                        $signed(exp_a.roll), exp_a.clip);
                    $display("%0t: actual   pitch %0d yaw %0d roll %0d clip %0b",
                        $time, $signed(got.pitch), $signed(got.yaw),
                        $signed(got.roll), got.clip);
                    errors++;
                end
            end
        end
    end

    task automatic test_corners();
        logic [15:0] lim[6];
        lim = '{16'sh4000, 16'shC000, 16'h0000, 16'h7FFF, 16'h8000, 16'h2D41};
        send_quat(16'h4000, 0, 0, 0, 0);          // identity
        send_quat(0, 0, 0, 0, 0);                 // zero by zero for yaw and roll
        send_quat(16'hC000, 0, 0, 0, 0);          // negated identity
        send_quat(16'h2D41, 0, 16'h2D41, 0, 0);   // argument just below one
        send_quat(16'h2D41, 16'h2D41, 0, 0, 0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 0); // clipped, out of range
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h7FFF, 0, 16'h7FFF, 0, 0);
        send_quat(0, 16'h4000, 0, 16'h4000, 0);   // negative clip
        send_quat(16'h4000, 0, 0, 16'h0001, 0);
        send_quat(0, 16'hFFFF, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            send_quat(lim[$urandom_range(0, 5)], lim[$urandom_range(0, 5)],
                lim[$urandom_range(0, 5)], lim[$urandom_range(0, 5)], 0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 120; i++)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 0);
        join
    endtask

    initial begin
        int guard;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_corners();
        test_random(900);
        test_backpressure();
        test_random(1000);
        s_tvalid = 1'b0;
        guard = 0;
        while (expected_angles.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        $display("sent %0d quaternions, checked %0d angle sets, %0d with clipped asin",
            items_sent, results_seen, clipped_seen);
        if (errors == 0 && expected_angles.size() == 0)
            $display("quaternion_to_euler verification clean");
        else
            $display("quaternion_to_euler verification failed");
        $finish;
    end

endmodule

`default_nettype wire
